/* rtl/assert_macros.svh */
// Assertion macros shared by the checker file of the orientation remap block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ORAG_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define ORAG_ASSERT(lbl, prop, msg) \
	`ORAG_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

/* rtl/orag_pkg.sv */
// Package: types, constants and register codes of the orientation remap address generator.
package orag_pkg;

	// Width of the size registers and of internal size arithmetic
	localparam int SZW = 13;
	localparam int STRIDE_W = 16;
	localparam int CH_W = 3;
	localparam int PIX_W = 32;
	localparam int ROW_W = 12;
	localparam int COL_W = 12;
	localparam int OFF_W = 28;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ORIENT_W = 4;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;

	// Queue between front and back
	localparam int Q_DEPTH = 4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIENT_CODE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PIX_CHANNELS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_STRIDE = 3'd4;

	// Orientation codes
	localparam logic [ORIENT_W-1:0] ORIENT_FLIP_H = 4'd2;
	localparam logic [ORIENT_W-1:0] ORIENT_ROT_180 = 4'd3;
	localparam logic [ORIENT_W-1:0] ORIENT_FLIP_V = 4'd4;
	localparam logic [ORIENT_W-1:0] ORIENT_TRANSPOSE = 4'd5;
	localparam logic [ORIENT_W-1:0] ORIENT_ROT_90 = 4'd6;
	localparam logic [ORIENT_W-1:0] ORIENT_TRANSVERSE = 4'd7;
	localparam logic [ORIENT_W-1:0] ORIENT_ROT_270 = 4'd8;

	localparam logic [CH_W-1:0] CH_RGB = 3'd3;
	localparam logic [CH_W-1:0] CH_RGBA = 3'd4;

	// Reset values of the registers
	localparam logic [SZW-1:0] RST_SRC_WIDTH = 13'd1;
	localparam logic [SZW-1:0] RST_SRC_HEIGHT = 13'd1;
	localparam logic [ORIENT_W-1:0] RST_ORIENT_CODE = 4'd1;
	localparam logic [CH_W-1:0] RST_PIX_CHANNELS = 3'd3;
	localparam logic [STRIDE_W-1:0] RST_DEST_STRIDE = 16'd12288;

	// Decoded, clamped configuration seen by front and back
	typedef struct packed {
		logic [SZW-1:0]      w;
		logic [SZW-1:0]      h;
		logic                flip;
		logic                mirror;
		logic                transpose;
		logic [CH_W-1:0]     ch;
		logic [STRIDE_W-1:0] stride;
	} cfg_t;

endpackage

/* rtl/orientation_remap_address_gen.sv */
// Top level of the orientation remap address generator: registers, front, queue and back.
// Source pixels enter one beat per clock while in_ready is high, in raster order; every
// beat leaves as exactly one result beat carrying the destination row, column and byte
// offset (row * dest_stride + column * channels, low 28 bits) under the selected EXIF
// orientation, the pixel unchanged, and frame_done on the last pixel of the frame.
// Sustained rate is one pixel per clock while out_ready is high; a beat passes the queue,
// then the back end's remap, multiply and offset-sum stages. A four-entry queue sits
// between the position tracker and the back end, so in_ready drops only when that queue
// is full; the back end keeps working while a result waits on out_ready. start_of_frame
// forces the beat to position (0,0). Orientation codes other than 2..8 map as identity, a
// zero size reads as 1, sizes clamp to MAX_WIDTH / MAX_HEIGHT, and a channel count other
// than 3 reads as 4. The configuration port is always ready; write it only while no beat
// is in flight. Register indexes: 0 src_width, 1 src_height, 2 orient_code,
// 3 pixel channel count, 4 dest_stride; other indexes are dropped.
module orientation_remap_address_gen
	import orag_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIX_W-1:0]      pixel_in,
	input  logic                  start_of_frame,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ROW_W-1:0]      dest_row,
	output logic [COL_W-1:0]      dest_col,
	output logic [OFF_W-1:0]      dest_offset,
	output logic [PIX_W-1:0]      pixel_out,
	output logic                  frame_done
);

	// Position counter widths follow the size limits; the 13-bit size registers
	// never exceed 8191, so larger limits need no wider counters.
	localparam int XW = (MAX_WIDTH > 8192) ? SZW : $clog2(MAX_WIDTH);
	localparam int YW = (MAX_HEIGHT > 8192) ? SZW : $clog2(MAX_HEIGHT);
	localparam logic [SZW-1:0] W_LIMIT = (MAX_WIDTH > 8191) ? 13'd8191 : SZW'(MAX_WIDTH);
	localparam logic [SZW-1:0] H_LIMIT = (MAX_HEIGHT > 8191) ? 13'd8191 : SZW'(MAX_HEIGHT);
	// queue entry: pixel, frame-end mark, row, column
	localparam int QW = PIX_W + 1 + YW + XW;

	logic [SZW-1:0]      src_width_q;
	logic [SZW-1:0]      src_height_q;
	logic [ORIENT_W-1:0] orient_code_q;
	logic [CH_W-1:0]     pix_channels_q;
	logic [STRIDE_W-1:0] dest_stride_q;

	cfg_t             cfg;
	logic             in_beat;
	logic [XW-1:0]    f_x;
	logic [YW-1:0]    f_y;
	logic             f_last;
	logic [QW-1:0]    q_wr_data;
	logic [QW-1:0]    q_rd_data;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;

	// Register write port: always ready, one register per beat.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q <= RST_SRC_WIDTH;
			src_height_q <= RST_SRC_HEIGHT;
			orient_code_q <= RST_ORIENT_CODE;
			pix_channels_q <= RST_PIX_CHANNELS;
			dest_stride_q <= RST_DEST_STRIDE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SRC_WIDTH: src_width_q <= cfg_data[SZW-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[SZW-1:0];
				REG_ORIENT_CODE: orient_code_q <= cfg_data[ORIENT_W-1:0];
				REG_PIX_CHANNELS: pix_channels_q <= cfg_data[CH_W-1:0];
				REG_DEST_STRIDE: dest_stride_q <= cfg_data;
				default: ; // unmapped index: drop the beat
			endcase
		end
	end

	// Decode and clamp the registers once; front and back share the result.
	always_comb begin
		cfg = '0;
		if (src_width_q == '0) begin
			cfg.w = SZW'(1);
		end else if (src_width_q > W_LIMIT) begin
			cfg.w = W_LIMIT;
		end else begin
			cfg.w = src_width_q;
		end
		if (src_height_q == '0) begin
			cfg.h = SZW'(1);
		end else if (src_height_q > H_LIMIT) begin
			cfg.h = H_LIMIT;
		end else begin
			cfg.h = src_height_q;
		end
		cfg.ch = (pix_channels_q == CH_RGB) ? CH_RGB : CH_RGBA;
		cfg.stride = dest_stride_q;
		unique case (orient_code_q)
			ORIENT_FLIP_H: cfg.flip = 1'b1;
			ORIENT_ROT_180: begin
				cfg.flip = 1'b1;
				cfg.mirror = 1'b1;
			end
			ORIENT_FLIP_V: cfg.mirror = 1'b1;
			ORIENT_TRANSPOSE: cfg.transpose = 1'b1;
			ORIENT_ROT_90: begin
				cfg.mirror = 1'b1;
				cfg.transpose = 1'b1;
			end
			ORIENT_TRANSVERSE: begin
				cfg.flip = 1'b1;
				cfg.mirror = 1'b1;
				cfg.transpose = 1'b1;
			end
			ORIENT_ROT_270: begin
				cfg.flip = 1'b1;
				cfg.transpose = 1'b1;
			end
			default: ; // identity, unknown codes included
		endcase
	end

	// Take a beat whenever the queue has room.
	assign in_ready = !q_full;
	assign in_beat = in_valid && in_ready;

	orag_front #(
		.XW(XW),
		.YW(YW)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.accept (in_beat),
		.sof    (start_of_frame),
		.x      (f_x),
		.y      (f_y),
		.last   (f_last)
	);

	assign q_wr_data = {pixel_in, f_last, f_y, f_x};

	orag_fifo #(
		.WIDTH(QW)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (in_beat),
		.wr_data (q_wr_data),
		.pop     (q_pop),
		.rd_data (q_rd_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	orag_back #(
		.XW(XW),
		.YW(YW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_empty     (q_empty),
		.q_x         (q_rd_data[XW-1:0]),
		.q_y         (q_rd_data[XW+YW-1:XW]),
		.q_last      (q_rd_data[XW+YW]),
		.q_pixel     (q_rd_data[QW-1:XW+YW+1]),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.dest_row    (dest_row),
		.dest_col    (dest_col),
		.dest_offset (dest_offset),
		.pixel_out   (pixel_out),
		.frame_done  (frame_done)
	);

endmodule

/* rtl/orag_fifo.sv */
// Short queue that decouples the classifying front from the address back end.
module orag_fifo
	import orag_pkg::*;
#(
	parameter int WIDTH = 58
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PW = $clog2(Q_DEPTH);
	localparam int CW = PW + 1;

	logic [WIDTH-1:0] mem_q [Q_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full = (count_q == CW'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/orag_front.sv */
// Front end: accepts pixel beats, tracks the source position and marks frame ends.
module orag_front
	import orag_pkg::*;
#(
	parameter int XW = 12,
	parameter int YW = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             accept,
	input  logic             sof,
	output logic [XW-1:0]    x,
	output logic [YW-1:0]    y,
	output logic             last
);

	logic [XW-1:0]  col_q;
	logic [YW-1:0]  row_q;
	logic [XW-1:0]  col_eff;
	logic [YW-1:0]  row_eff;
	logic [SZW-1:0] w_m1;
	logic [SZW-1:0] h_m1;
	logic           last_col;
	logic           last_row;

	always_comb begin
		// start of frame forces position (0,0)
		col_eff = sof ? '0 : col_q;
		row_eff = sof ? '0 : row_q;
		w_m1 = cfg.w - 1'b1;
		h_m1 = cfg.h - 1'b1;
		// a counter past the size (size changed mid-frame) pins to the last one
		x = (SZW'(col_eff) >= cfg.w) ? XW'(w_m1) : col_eff;
		y = (SZW'(row_eff) >= cfg.h) ? YW'(h_m1) : row_eff;
		last_col = (SZW'(x) == w_m1);
		last_row = (SZW'(y) == h_m1);
		last = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : y + 1'b1;
			end else begin
				col_q <= x + 1'b1;
				row_q <= y;
			end
		end
	end

endmodule

/* rtl/orag_back.sv */
// Back end: remaps the position, forms the byte offset and holds the result beat.
module orag_back
	import orag_pkg::*;
#(
	parameter int XW = 12,
	parameter int YW = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 q_empty,
	input  logic [XW-1:0]        q_x,
	input  logic [YW-1:0]        q_y,
	input  logic                 q_last,
	input  logic [PIX_W-1:0]     q_pixel,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ROW_W-1:0]     dest_row,
	output logic [COL_W-1:0]     dest_col,
	output logic [OFF_W-1:0]     dest_offset,
	output logic [PIX_W-1:0]     pixel_out,
	output logic                 frame_done
);

	localparam int RP_W = SZW + STRIDE_W;
	localparam int CP_W = SZW + CH_W;

	logic                 v_s1, v_s2, v_s3;
	logic                 rdy_s1, rdy_s2, rdy_s3;
	logic [SZW-1:0]       drow_s1, dcol_s1;
	logic [PIX_W-1:0]     pixel_s1, pixel_s2, pixel_s3;
	logic                 last_s1, last_s2, last_s3;
	logic [SZW-1:0]       drow_s2, dcol_s2;
	logic [OFF_W-1:0]     rprod_s2;
	logic [CP_W-1:0]      cprod_s2;
	logic [ROW_W-1:0]     row_s3;
	logic [COL_W-1:0]     col_s3;
	logic [OFF_W-1:0]     off_s3;
	logic [SZW-1:0]       hx, vy;
	logic [RP_W-1:0]      rprod;

	assign rdy_s3 = !v_s3 || out_ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign q_pop = !q_empty && rdy_s1;

	always_comb begin
		hx = cfg.flip ? (cfg.w - 1'b1 - SZW'(q_x)) : SZW'(q_x);
		vy = cfg.mirror ? (cfg.h - 1'b1 - SZW'(q_y)) : SZW'(q_y);
		rprod = RP_W'(drow_s1) * RP_W'(cfg.stride);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= !q_empty;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// stage 1: orientation remap
	always_ff @(posedge clk) begin
		if (q_pop) begin
			drow_s1 <= cfg.transpose ? hx : vy;
			dcol_s1 <= cfg.transpose ? vy : hx;
			pixel_s1 <= q_pixel;
			last_s1 <= q_last;
		end
	end

	// stage 2: row and column products
	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			rprod_s2 <= rprod[OFF_W-1:0];
			cprod_s2 <= CP_W'(dcol_s1) * CP_W'(cfg.ch);
			drow_s2 <= drow_s1;
			dcol_s2 <= dcol_s1;
			pixel_s2 <= pixel_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: offset sum into the output register
	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			off_s3 <= rprod_s2 + OFF_W'(cprod_s2);
			row_s3 <= drow_s2[ROW_W-1:0];
			col_s3 <= dcol_s2[COL_W-1:0];
			pixel_s3 <= pixel_s2;
			last_s3 <= last_s2;
		end
	end

	assign out_valid = v_s3;
	assign dest_row = row_s3;
	assign dest_col = col_s3;
	assign dest_offset = off_s3;
	assign pixel_out = pixel_s3;
	assign frame_done = last_s3;

endmodule

/* rtl/orag_checker.sv */
// Port-level checker of the orientation remap address generator, bound to the top level.
`include "assert_macros.svh"

module orag_checker
	import orag_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [PIX_W-1:0]      pixel_in,
	input logic                  start_of_frame,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [ROW_W-1:0]      dest_row,
	input logic [COL_W-1:0]      dest_col,
	input logic [OFF_W-1:0]      dest_offset,
	input logic [PIX_W-1:0]      pixel_out,
	input logic                  frame_done
);

	// beats taken but not yet delivered
	logic [3:0] pending_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_beat && !out_beat) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_beat && !in_beat) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`ORAG_ASSERT(a_out_hold,
		out_valid && !out_ready |=> out_valid && $stable(dest_row) && $stable(dest_col)
			&& $stable(dest_offset) && $stable(pixel_out) && $stable(frame_done),
		"result beat changed while stalled")
	`ORAG_ASSERT(a_in_hold,
		in_valid && !in_ready |=> in_valid && $stable(pixel_in) && $stable(start_of_frame),
		"input beat changed while stalled")
	`ORAG_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "register write port not ready")
	`ORAG_ASSERT(a_no_phantom, out_valid |-> pending_q != 4'd0, "result beat without a pending input beat")
	`ORAG_ASSERT(a_stall_busy, !in_ready |-> pending_q != 4'd0, "input stalled while nothing is in flight")

endmodule

bind orientation_remap_address_gen orag_checker u_orag_checker (.*);
